// ===== design/nfpmr_pkg.sv =====
// Shared types, constants and float-key helpers for the non-finite pixel repair block.
// No dependencies; used by every module in the design folder except nfpmr_fifo.
package nfpmr_pkg;

   localparam int CHANNELS   = 4;
   localparam int CELLS      = 9;
   localparam int PAIRS      = 36;
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH  = 8;
   // line store depth; column counter and result column are 11 bits wide
   localparam int MAX_LINE_PIXELS = 2048;

   // Register indices on the csr port
   localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_REGION_X_START = 3'd2;
   localparam logic [2:0] REG_REGION_X_END   = 3'd3;
   localparam logic [2:0] REG_REGION_Y_START = 3'd4;
   localparam logic [2:0] REG_REGION_Y_END   = 3'd5;

   typedef struct packed {
      logic [11:0] image_width;
      logic [15:0] image_height;
      logic [11:0] region_x_start;
      logic [11:0] region_x_end;
      logic [15:0] region_y_start;
      logic [15:0] region_y_end;
   } cfg_type;

   // One classified input beat: window after the shift plus what to emit from it
   typedef struct packed {
      logic [CELLS-1:0][127:0] win;
      logic [3:0]              emit;
      logic [2:0]              xok;
      logic [2:0]              yok;
      logic [1:0]              xin;
      logic [1:0]              yin;
      logic [10:0]             col;
      logic [15:0]             row;
   } job_type;

   typedef struct packed {
      logic [CHANNELS-1:0][31:0] chan;
      logic [10:0]               col;
      logic [15:0]               row;
      logic                      last;
   } rsp_type;

   function automatic logic chan_finite(input logic [31:0] b);
      return b[30:23] != 8'hFF;
   endfunction

   function automatic logic pix_finite(input logic [127:0] p);
      return chan_finite(p[31:0]) && chan_finite(p[63:32]) &&
             chan_finite(p[95:64]) && chan_finite(p[127:96]);
   endfunction

   // Order-preserving key: -0 sorts below +0
   function automatic logic [31:0] to_key(input logic [31:0] b);
      return b[31] ? ~b : (b | 32'h8000_0000);
   endfunction

   function automatic logic [31:0] from_key(input logic [31:0] k);
      return k[31] ? {1'b0, k[30:0]} : ~k;
   endfunction

endpackage

// ===== design/nonfinite_pixel_median_repair.sv =====
// Throughput: one input beat per cycle while full is low; one result per cycle from the
// median unit while the result queue has room, so on the last row of a frame up to four
// results per beat set the pace.
// Reset (synchronous): counters, queues and pipeline cleared, registers to defaults;
// line stores hold no defined contents and need no clearing.
// Top level: csr registers, front end, job queue, back end, result queue.
module nonfinite_pixel_median_repair (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_in_red,
   input  logic [31:0] req_in_green,
   input  logic [31:0] req_in_blue,
   input  logic [31:0] req_in_alpha,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_out_red,
   output logic [31:0] rsp_out_green,
   output logic [31:0] rsp_out_blue,
   output logic [31:0] rsp_out_alpha,
   output logic [10:0] rsp_out_column,
   output logic [15:0] rsp_out_row,
   output logic        rsp_last_of_run,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import nfpmr_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= 12'd2048;
         cfg_ff.image_height   <= 16'd1;
         cfg_ff.region_x_start <= '0;
         cfg_ff.region_x_end   <= '0;
         cfg_ff.region_y_start <= '0;
         cfg_ff.region_y_end   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:    cfg_ff.image_width    <= csr_data[11:0];
            REG_IMAGE_HEIGHT:   cfg_ff.image_height   <= csr_data;
            REG_REGION_X_START: cfg_ff.region_x_start <= csr_data[11:0];
            REG_REGION_X_END:   cfg_ff.region_x_end   <= csr_data[11:0];
            REG_REGION_Y_START: cfg_ff.region_y_start <= csr_data;
            REG_REGION_Y_END:   cfg_ff.region_y_end   <= csr_data;
            default: ;
         endcase
      end
   end

   localparam int QCW = $clog2(QUEUE_DEPTH+1);
   localparam int OCW = $clog2(OUT_DEPTH+1);

   logic          accept, job_valid, job_pop, room, rsp_push;
   job_type       job_in, job_out;
   rsp_type       rsp_in, rsp_out;
   logic [QCW-1:0] q_count;
   logic [OCW-1:0] o_count;
   logic          s_inflight;

   assign accept = push && !full;
   // the beat in the front's second stage always finds a queue slot
   assign full   = (32'(q_count) + 32'(job_valid)) >= 32'(QUEUE_DEPTH);

   nfpmr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .pix       ({req_in_alpha, req_in_blue, req_in_green, req_in_red}),
      .job_valid (job_valid),
      .job       (job_in)
   );

   nfpmr_fifo #(.T(job_type), .DEPTH(QUEUE_DEPTH)) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_valid),
      .din   (job_in),
      .pop   (job_pop),
      .dout  (job_out),
      .count (q_count)
   );

   // credit check covers the two median stages in flight
   logic [1:0] inflight;
   logic u_back_s1, u_back_s2;
   assign inflight   = 2'(u_back_s1) + 2'(u_back_s2);
   always_ff @(posedge clock) begin
      if (reset) begin
         u_back_s1 <= 1'b0;
         u_back_s2 <= 1'b0;
      end else begin
         u_back_s1 <= room && s_inflight;
         u_back_s2 <= u_back_s1;
      end
   end
   assign room = (32'(o_count) + 32'(inflight)) < 32'(OUT_DEPTH - 1);

   nfpmr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_out),
      .job_avail (q_count != '0),
      .job_pop   (job_pop),
      .room      (room),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );
   assign s_inflight = 1'b1;

   nfpmr_fifo #(.T(rsp_type), .DEPTH(OUT_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .pop   (pop && !empty),
      .dout  (rsp_out),
      .count (o_count)
   );

   assign empty           = (o_count == '0);
   assign rsp_out_red     = rsp_out.chan[0];
   assign rsp_out_green   = rsp_out.chan[1];
   assign rsp_out_blue    = rsp_out.chan[2];
   assign rsp_out_alpha   = rsp_out.chan[3];
   assign rsp_out_column  = rsp_out.col;
   assign rsp_out_row     = rsp_out.row;
   assign rsp_last_of_run = rsp_out.last;

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (32'(o_count) < 32'(OUT_DEPTH)))
      else $error("result queue overflow");

   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (32'(q_count) < 32'(QUEUE_DEPTH)))
      else $error("job queue overflow");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("results present after reset");
endmodule

// ===== design/nfpmr_fifo.sv =====
// Small register-based queue, first word fall-through.
// Depends on nothing; the entry type is a parameter.
module nfpmr_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  T                               din,
   input  logic                           pop,
   output T                               dout,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   T              mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);
   assign dout    = mem[rd_ptr_ff];
   assign count   = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= din;
   end
endmodule

// ===== design/nfpmr_front.sv =====
// Front end: counters, line stores, 3x3 window and classification of each beat.
// Depends on nfpmr_pkg.
module nfpmr_front (
   input  logic              clock,
   input  logic              reset,
   input  nfpmr_pkg::cfg_type cfg,
   input  logic              accept,
   input  logic [127:0]      pix,
   output logic              job_valid,
   output nfpmr_pkg::job_type job
);
   import nfpmr_pkg::*;

   localparam int AW = $clog2(MAX_LINE_PIXELS);

   logic [127:0] older_mem [MAX_LINE_PIXELS];
   logic [127:0] newer_mem [MAX_LINE_PIXELS];

   logic [10:0]   col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [11:0]   w_eff;
   logic [15:0]   h_eff;
   logic          row_end, last_row;
   logic [31:0]   col32;
   logic [AW-1:0] idx;

   logic          f1_valid_ff;
   logic [127:0]  f1_pix_ff;
   logic [10:0]   f1_col_ff;
   logic [15:0]   f1_row_ff;
   logic [AW-1:0] f1_idx_ff;
   logic          f1_rowend_ff, f1_lastrow_ff;
   logic [127:0]  rd_older_ff, rd_newer_ff;
   logic          hit_ff;
   logic [127:0]  fwd_older_ff, fwd_newer_ff;
   logic [CELLS-1:0][127:0] win_ff, win_in;
   logic [127:0]  older_d, newer_d;

   always_comb begin
      if (cfg.image_width == '0) w_eff = 12'd1;
      else if (32'(cfg.image_width) > 32'(MAX_LINE_PIXELS)) w_eff = 12'(MAX_LINE_PIXELS);
      else w_eff = cfg.image_width;
      h_eff = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;
   end

   assign row_end  = 13'(col_ff) >= (13'(w_eff) - 13'd1);
   assign last_row = 17'(row_ff) >= (17'(h_eff) - 17'd1);
   assign col32    = 32'(col_ff);
   assign idx      = (col32 < 32'(MAX_LINE_PIXELS)) ? col32[AW-1:0] : '0;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= accept;
      end
   end

   // Line store read on accept; a write to the same entry in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_older_ff   <= older_mem[idx];
         rd_newer_ff   <= newer_mem[idx];
         f1_pix_ff     <= pix;
         f1_col_ff     <= col_ff;
         f1_row_ff     <= row_ff;
         f1_idx_ff     <= idx;
         f1_rowend_ff  <= row_end;
         f1_lastrow_ff <= last_row;
         hit_ff        <= f1_valid_ff && (f1_idx_ff == idx);
         fwd_older_ff  <= newer_d;
         fwd_newer_ff  <= f1_pix_ff;
      end
      if (f1_valid_ff) begin
         older_mem[f1_idx_ff] <= newer_d;
         newer_mem[f1_idx_ff] <= f1_pix_ff;
         win_ff               <= win_in;
      end
   end

   assign older_d = hit_ff ? fwd_older_ff : rd_older_ff;
   assign newer_d = hit_ff ? fwd_newer_ff : rd_newer_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = older_d;
      win_in[5] = newer_d;
      win_in[8] = f1_pix_ff;
   end

   // Classification
   logic signed [17:0] xs, ys, xl, xh, yl, yh, wm1, hm1;
   logic               region_on;

   always_comb begin
      region_on = (cfg.region_x_end > cfg.region_x_start) &&
                  (cfg.region_y_end > cfg.region_y_start);
      wm1 = 18'(w_eff) - 18'sd1;
      hm1 = 18'(h_eff) - 18'sd1;
      xl  = region_on ? 18'(cfg.region_x_start) : 18'sd0;
      yl  = region_on ? 18'(cfg.region_y_start) : 18'sd0;
      xh  = 18'(w_eff);
      yh  = 18'(h_eff);
      if (region_on && (cfg.region_x_end < w_eff)) xh = 18'(cfg.region_x_end);
      if (region_on && (cfg.region_y_end < h_eff)) yh = 18'(cfg.region_y_end);

      job.win = win_in;
      job.col = f1_col_ff;
      job.row = f1_row_ff;
      for (int i = 0; i < 3; i++) begin
         xs = 18'(f1_col_ff) - 18'sd2 + 18'(i);
         ys = 18'(f1_row_ff) - 18'sd2 + 18'(i);
         job.xok[i] = (xs > 18'sd0) && (xs < wm1);
         job.yok[i] = (ys > 18'sd0) && (ys < hm1);
      end
      for (int i = 0; i < 2; i++) begin
         xs = 18'(f1_col_ff) - 18'sd1 + 18'(i);
         ys = 18'(f1_row_ff) - 18'sd1 + 18'(i);
         job.xin[i] = (xs >= xl) && (xs < xh);
         job.yin[i] = (ys >= yl) && (ys < yh);
      end
      job.emit[0] = (f1_col_ff != '0) && (f1_row_ff != '0);
      job.emit[1] = f1_rowend_ff && (f1_row_ff != '0);
      job.emit[2] = f1_lastrow_ff && (f1_col_ff != '0);
      job.emit[3] = f1_lastrow_ff && f1_rowend_ff;
   end

   assign job_valid = f1_valid_ff;
endmodule

// ===== design/nfpmr_back.sv =====
// Back end: walks the pending emits of each job, one pixel a cycle while room is high,
// through a gather stage and a compare stage, then ranks and selects.  Depends on nfpmr_pkg.
module nfpmr_back (
   input  logic               clock,
   input  logic               reset,
   input  nfpmr_pkg::job_type job,
   input  logic               job_avail,
   output logic               job_pop,
   input  logic               room,
   output logic               rsp_push,
   output nfpmr_pkg::rsp_type rsp
);
   import nfpmr_pkg::*;

   job_type   cur_ff;
   logic      cur_v_ff;
   logic [3:0] rem_ff, rem_in, pick, rem_after;
   logic      issue, advance;

   always_comb begin
      pick = rem_ff & (~rem_ff + 4'd1);
      rem_after = rem_ff & ~pick;
      issue   = cur_v_ff && (rem_ff != '0) && room;
      advance = !cur_v_ff || (rem_ff == '0) || (issue && (rem_after == '0));
      job_pop = advance && job_avail;
      rem_in  = issue ? rem_after : rem_ff;
      if (job_pop) rem_in = job.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         if (advance) cur_v_ff <= job_avail;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) cur_ff <= job;
   end

   // Stage 1: gather candidates for the chosen emit
   logic                            s1_v_ff;
   logic [CELLS-1:0][CHANNELS-1:0][31:0] s1_key_ff, s1_key_in;
   logic [CELLS-1:0]                s1_vld_ff, s1_vld_in;
   logic [127:0]                    s1_ctr_ff, s1_ctr_in;
   logic                            s1_rep_ff, s1_rep_in;
   logic [10:0]                     s1_col_ff, s1_col_in;
   logic [15:0]                     s1_row_ff, s1_row_in;
   logic                            s1_last_ff;
   logic                            rs, cs;
   logic [3:0]                      ctr_sel;

   always_comb begin
      rs = pick[2] || pick[3];
      cs = pick[1] || pick[3];
      ctr_sel = 4'd4 + (rs ? 4'd3 : 4'd0) + {3'd0, cs};
      s1_ctr_in = cur_ff.win[ctr_sel];
      s1_rep_in = !pix_finite(s1_ctr_in) && cur_ff.xin[cs] && cur_ff.yin[rs];
      s1_col_in = cur_ff.col - 11'd1 + 11'(cs);
      s1_row_in = cur_ff.row - 16'd1 + 16'(rs);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s1_vld_in[r*3+c] = (r >= 32'(rs)) && (r <= 32'(rs) + 2) &&
                               (c >= 32'(cs)) && (c <= 32'(cs) + 2) &&
                               cur_ff.xok[c] && cur_ff.yok[r] &&
                               pix_finite(cur_ff.win[r*3+c]);
            for (int k = 0; k < CHANNELS; k++)
               s1_key_in[r*3+c][k] = to_key(cur_ff.win[r*3+c][k*32 +: 32]);
         end
      end
   end

   // Stage 2: pairwise compares, lt = later key below earlier key
   logic                            s2_v_ff;
   logic [CHANNELS-1:0][CELLS-1:0][CELLS-1:0] s2_lt_ff, s2_lt_in;
   logic [CELLS-1:0][CHANNELS-1:0][31:0] s2_key_ff;
   logic [CELLS-1:0]                s2_vld_ff;
   logic [127:0]                    s2_ctr_ff;
   logic                            s2_rep_ff;
   logic [10:0]                     s2_col_ff;
   logic [15:0]                     s2_row_ff;
   logic                            s2_last_ff;

   always_comb begin
      s2_lt_in = '0;
      for (int k = 0; k < CHANNELS; k++)
         for (int a = 0; a < CELLS; a++)
            for (int b = a + 1; b < CELLS; b++)
               s2_lt_in[k][a][b] = s1_key_ff[b][k] < s1_key_ff[a][k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_key_ff  <= s1_key_in;
      s1_vld_ff  <= s1_vld_in;
      s1_ctr_ff  <= s1_ctr_in;
      s1_rep_ff  <= s1_rep_in;
      s1_col_ff  <= s1_col_in;
      s1_row_ff  <= s1_row_in;
      s1_last_ff <= (rem_after == '0);
      s2_lt_ff   <= s2_lt_in;
      s2_key_ff  <= s1_key_ff;
      s2_vld_ff  <= s1_vld_ff;
      s2_ctr_ff  <= s1_ctr_ff;
      s2_rep_ff  <= s1_rep_ff;
      s2_col_ff  <= s1_col_ff;
      s2_row_ff  <= s1_row_ff;
      s2_last_ff <= s1_last_ff;
   end

   // Rank and select the lower median
   logic [3:0] n, kth, rank;
   logic       precedes;

   always_comb begin
      n = '0;
      for (int i = 0; i < CELLS; i++) n = n + 4'(s2_vld_ff[i]);
      kth = (n - 4'd1) >> 1;
      rsp.col  = s2_col_ff;
      rsp.row  = s2_row_ff;
      rsp.last = s2_last_ff;
      rank     = '0;
      precedes = 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
         rsp.chan[k] = s2_ctr_ff[k*32 +: 32];
         if (s2_rep_ff && (n != '0) && !chan_finite(s2_ctr_ff[k*32 +: 32])) begin
            for (int i = 0; i < CELLS; i++) begin
               rank = '0;
               for (int j = 0; j < CELLS; j++) begin
                  if (j < i) precedes = !s2_lt_ff[k][j][i];
                  else if (j > i) precedes = s2_lt_ff[k][i][j];
                  else precedes = 1'b0;
                  rank = rank + 4'(s2_vld_ff[j] && precedes);
               end
               if (s2_vld_ff[i] && (rank == kth)) rsp.chan[k] = from_key(s2_key_ff[i][k]);
            end
         end
      end
   end

   assign rsp_push = s2_v_ff;
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for nonfinite_pixel_median_repair: directed table, then random frames.
// Depends on design/nfpmr_pkg.sv and design/nonfinite_pixel_median_repair.sv.
// A behavioural 3x3 masked-median predictor holds the expected result beats.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import nfpmr_pkg::*;

   localparam int LINE_PIXELS = MAX_LINE_PIXELS;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 300;

   typedef struct {
      logic [31:0] r, g, b, a;
      bit          typed;
   } pixel_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        full, empty;
   logic        pop = 0;
   logic [31:0] req_in_red = 0, req_in_green = 0, req_in_blue = 0, req_in_alpha = 0;
   logic [31:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic [10:0] rsp_out_column;
   logic [15:0] rsp_out_row;
   logic        rsp_last_of_run;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_data = 0;
   logic        pix_typed = 0;

   nonfinite_pixel_median_repair i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [11:0]  cfg_width;
   logic [15:0]  cfg_height;
   logic [11:0]  cfg_x0, cfg_x1;
   logic [15:0]  cfg_y0, cfg_y1;
   logic [127:0] prev_line [LINE_PIXELS];
   logic [127:0] last_line [LINE_PIXELS];
   logic [127:0] win [3][3];
   logic [10:0]  col_pos;
   logic [15:0]  row_pos;

   rsp_type repaired_q[$];
   int      errors = 0;
   int      pixels_in = 0, beats_out = 0, repairs_seen = 0, frames_done = 0;
   bit      hold_req = 0;
   int      burst_left = 0;

   function automatic bit finite32(logic [31:0] v);
      return v[30:23] != 8'hFF;
   endfunction

   function automatic bit finite_px(logic [127:0] p);
      return finite32(p[31:0]) && finite32(p[63:32]) && finite32(p[95:64])
             && finite32(p[127:96]);
   endfunction

   function automatic int eff_w();
      if (cfg_width == 0) return 1;
      if (cfg_width > LINE_PIXELS) return LINE_PIXELS;
      return cfg_width;
   endfunction

   function automatic int eff_h();
      return cfg_height == 0 ? 1 : cfg_height;
   endfunction

   function automatic bit repair_zone(int x, int y, int w, int h);
      int xl, xh, yl, yh;
      xl = 0; xh = w; yl = 0; yh = h;
      if (cfg_x1 > cfg_x0 && cfg_y1 > cfg_y0) begin
         xl = cfg_x0;
         yl = cfg_y0;
         xh = cfg_x1 < w ? cfg_x1 : w;
         yh = cfg_y1 < h ? cfg_y1 : h;
      end
      return x >= xl && x < xh && y >= yl && y < yh;
   endfunction

   // order key: -0 below +0, negatives reversed
   function automatic logic [31:0] sort_key(logic [31:0] v);
      return v[31] ? ~v : (v | 32'h8000_0000);
   endfunction

   function automatic rsp_type repair_pixel(int cx, int cy, int rs, int cs);
      rsp_type     res;
      logic [127:0] ctr, p;
      logic [31:0] keys [4][9];
      logic [31:0] kv, pick;
      int n, w, h, ri, ci, j;
      w = eff_w(); h = eff_h();
      n = 0;
      ctr = win[1+rs][1+cs];
      for (int ch = 0; ch < 4; ch++) res.chan[ch] = ctr[32*ch +: 32];
      if (!finite_px(ctr) && repair_zone(cx, cy, w, h)) begin
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               ri = 1 + rs + dy; ci = 1 + cs + dx;
               if (!(cx+dx > 0 && cx+dx < w-1 && cy+dy > 0 && cy+dy < h-1)) continue;
               if (ri < 0 || ri > 2 || ci < 0 || ci > 2) continue;
               p = win[ri][ci];
               if (!finite_px(p)) continue;
               for (int ch = 0; ch < 4; ch++) keys[ch][n] = sort_key(p[32*ch +: 32]);
               n++;
            end
         for (int ch = 0; ch < 4; ch++) begin
            if (n == 0 || finite32(res.chan[ch])) continue;
            for (int i = 1; i < n; i++) begin
               kv = keys[ch][i];
               for (j = i; j > 0 && keys[ch][j-1] > kv; j--) keys[ch][j] = keys[ch][j-1];
               keys[ch][j] = kv;
            end
            pick = keys[ch][(n-1)/2];
            res.chan[ch] = pick[31] ? {1'b0, pick[30:0]} : ~pick;
            repairs_seen++;
         end
      end
      res.col = cx[10:0];
      res.row = cy[15:0];
      res.last = 1'b0;
      return res;
   endfunction

   task automatic predict_pixel(logic [127:0] px);
      rsp_type outs[$];
      int w, h, c, r;
      bit row_end, last_row;
      w = eff_w(); h = eff_h();
      c = col_pos; r = row_pos;
      row_end = c >= w - 1;
      last_row = r >= h - 1;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = prev_line[col_pos];
      win[1][2] = last_line[col_pos];
      win[2][2] = px;
      prev_line[col_pos] = last_line[col_pos];
      last_line[col_pos] = px;
      if (c >= 1 && r >= 1) outs.push_back(repair_pixel(c-1, r-1, 0, 0));
      if (row_end && r >= 1) outs.push_back(repair_pixel(c, r-1, 0, 1));
      if (last_row && c >= 1) outs.push_back(repair_pixel(c-1, r, 1, 0));
      if (last_row && row_end) outs.push_back(repair_pixel(c, r, 1, 1));
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      if (row_end) begin
         col_pos = '0;
         if (last_row) frames_done++;
         row_pos = last_row ? 16'd0 : row_pos + 16'd1;
      end else begin
         col_pos = col_pos + 11'd1;
      end
      foreach (outs[i]) repaired_q.push_back(outs[i]);
   endtask

   // checker and predictor, both on the sampled edge values
   always @(posedge clock) begin
      rsp_type e;
      rsp_type typed_res;
      int qn;
      if (!reset && pop && !empty) begin
         beats_out++;
         if (repaired_q.size() == 0) begin
            $error("result beat with nothing expected: col %0d row %0d",
                   rsp_out_column, rsp_out_row);
            errors++;
         end else begin
            e = repaired_q.pop_front();
            if (rsp_out_red !== e.chan[0]) begin
               $error("out_red exp %h got %h", e.chan[0], rsp_out_red); errors++;
            end
            if (rsp_out_green !== e.chan[1]) begin
               $error("out_green exp %h got %h", e.chan[1], rsp_out_green); errors++;
            end
            if (rsp_out_blue !== e.chan[2]) begin
               $error("out_blue exp %h got %h", e.chan[2], rsp_out_blue); errors++;
            end
            if (rsp_out_alpha !== e.chan[3]) begin
               $error("out_alpha exp %h got %h", e.chan[3], rsp_out_alpha); errors++;
            end
            if (rsp_out_column !== e.col) begin
               $error("out_column exp %0d got %0d", e.col, rsp_out_column); errors++;
            end
            if (rsp_out_row !== e.row) begin
               $error("out_row exp %0d got %0d", e.row, rsp_out_row); errors++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run exp %0d got %0d", e.last, rsp_last_of_run); errors++;
            end
         end
      end
      if (!reset && push && !full) begin
         pixels_in++;
         qn = repaired_q.size();
         predict_pixel({req_in_alpha, req_in_blue, req_in_green, req_in_red});
         if (pix_typed) begin
            // 1x1 frame: pixel comes straight back, untouched
            while (repaired_q.size() > qn) void'(repaired_q.pop_back());
            typed_res.chan = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
            typed_res.col = '0;
            typed_res.row = '0;
            typed_res.last = 1'b1;
            repaired_q.push_back(typed_res);
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      int idle_cycles;
      if ((push && !full) || (pop && !empty) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            mode = (cyc / 97) % 4;
            case (mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= (cyc % 5) != 0;
               default: pop <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // leaves the write enable high; set_frame drops it after the last write
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:    cfg_width = val[11:0];
         REG_IMAGE_HEIGHT:   cfg_height = val;
         REG_REGION_X_START: cfg_x0 = val[11:0];
         REG_REGION_X_END:   cfg_x1 = val[11:0];
         REG_REGION_Y_START: cfg_y0 = val;
         REG_REGION_Y_END:   cfg_y1 = val;
         default: ;
      endcase
   endtask

   task automatic set_frame(int w, int h, int x0, int x1, int y0, int y1);
      write_reg(REG_IMAGE_WIDTH, 16'(w));
      write_reg(REG_IMAGE_HEIGHT, 16'(h));
      write_reg(REG_REGION_X_START, 16'(x0));
      write_reg(REG_REGION_X_END, 16'(x1));
      write_reg(REG_REGION_Y_START, 16'(y0));
      write_reg(REG_REGION_Y_END, 16'(y1));
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic [31:0] a, bit typed);
      int gap;
      push <= 1'b1;
      req_in_red <= r;
      req_in_green <= g;
      req_in_blue <= b;
      req_in_alpha <= a;
      pix_typed <= typed;
      do @(posedge clock); while (full);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every expected beat, then let the pipeline settle
   task automatic drain();
      if (push) push <= 1'b0;
      while (repaired_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_chan();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 19))
         0: v[30:23] = 8'hFF;                  // NaN, or infinity if mantissa is zero
         1: v = {v[31], 8'hFF, 23'd0};          // infinity
         2: v = {v[31], 31'd0};                 // signed zero
         default: if (v[30:23] == 8'hFF) v[23] = 1'b0;
      endcase
      return v;
   endfunction

   task automatic send_frame(int items, bit long_hold);
      for (int i = 0; i < items; i++) begin
         if (long_hold && i == 2) hold_req = 1'b1;
         send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), 1'b0);
      end
      drain();
   endtask

   pixel_row_type stim_rows [22];

   initial begin
      int w, h, x0, x1, y0, y1, sent;
      int wv[6];
      int hv[6];
      // 1x1 frames: every pixel is on the border and passes as it came
      stim_rows[0] = '{32'h7FC0_0000, 32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 1};
      stim_rows[1] = '{32'h7F80_0000, 32'hFF80_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1};
      stim_rows[2] = '{32'h0000_0001, 32'h8000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 1};
      stim_rows[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1};
      stim_rows[4] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1};
      stim_rows[5] = '{32'hFF80_0001, 32'h7F80_0001, 32'h0080_0000, 32'h807F_FFFF, 1};
      // 4x4 frame: interior pixels repaired from each other, -0 against +0
      stim_rows[6]  = '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 0};
      stim_rows[7]  = '{32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0};
      stim_rows[8]  = '{32'h4000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 0};
      stim_rows[9]  = '{32'hFF80_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 0};
      stim_rows[10] = '{32'h4040_0000, 32'h4040_0000, 32'h4040_0000, 32'h4040_0000, 0};
      stim_rows[11] = '{32'h7FC0_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 0};
      stim_rows[12] = '{32'h8000_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h0000_0000, 0};
      stim_rows[13] = '{32'h4080_0000, 32'h4080_0000, 32'h4080_0000, 32'h4080_0000, 0};
      stim_rows[14] = '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0};
      stim_rows[15] = '{32'h0000_0000, 32'hC000_0000, 32'h8000_0000, 32'h3F80_0000, 0};
      stim_rows[16] = '{32'h7F80_0000, 32'h7FC0_0000, 32'hFF80_0000, 32'hFFC0_0000, 0};
      stim_rows[17] = '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 0};
      stim_rows[18] = '{32'h4040_0000, 32'h4040_0000, 32'h4040_0000, 32'h4040_0000, 0};
      stim_rows[19] = '{32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0};
      stim_rows[20] = '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0};
      stim_rows[21] = '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 0};

      cfg_width = 12'd2048; cfg_height = 16'd1;
      cfg_x0 = '0; cfg_x1 = '0; cfg_y0 = '0; cfg_y1 = '0;
      col_pos = '0; row_pos = '0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_frame(1, 1, 0, 0, 0, 0);
      for (int i = 0; i < 6; i++)
         send_pixel(stim_rows[i].r, stim_rows[i].g, stim_rows[i].b, stim_rows[i].a,
                    stim_rows[i].typed);
      drain();
      set_frame(4, 4, 0, 0, 0, 0);
      for (int i = 6; i < 22; i++)
         send_pixel(stim_rows[i].r, stim_rows[i].g, stim_rows[i].b, stim_rows[i].a,
                    stim_rows[i].typed);
      drain();

      // extreme sizes and registers: zero sizes, width beyond the line store, clipped region
      set_frame(0, 0, 4095, 0, 65535, 0);
      send_frame(1, 0);
      set_frame(4095, 1, 0, 4095, 0, 65535);
      send_frame(40, 0);
      // narrowing the width mid-row ends the row at once and realigns the counters
      set_frame(1, 1, 0, 0, 0, 0);
      send_frame(1, 0);
      // fill-up: receiver holds off while the sender keeps going
      set_frame(10, 6, 1, 9, 1, 5);
      send_frame(60, 1);

      wv = '{1, 2, 3, 5, 8, 12};
      hv = '{1, 2, 3, 4, 5, 7};
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = wv[$urandom_range(0, 5)];
         h = hv[$urandom_range(0, 5)];
         case ($urandom_range(0, 5))
            0: begin x0 = 0; x1 = 0; y0 = 0; y1 = 0; end
            1: begin x0 = $urandom_range(0, 4095); x1 = 4095;
                     y0 = $urandom_range(0, 3); y1 = 65535; end
            2: begin x0 = w; x1 = w + 2; y0 = 0; y1 = h; end
            3: begin x0 = 5; x1 = 2; y0 = 1; y1 = 3; end
            default: begin x0 = $urandom_range(0, w); x1 = $urandom_range(0, w + 1);
                           y0 = $urandom_range(0, h); y1 = $urandom_range(0, h + 1); end
         endcase
         set_frame(w, h, x0, x1, y0, y1);
         send_frame(w * h, 0);
         sent += w * h;
      end

      drain();
      $display("covered %0d pixels in %0d frames, %0d result beats, %0d channels repaired",
               pixels_in, frames_done, beats_out, repairs_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
